/* sv/sdtq_pkg.sv */
package sdtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_SET    = 2'd2;
  localparam logic [1:0] REQ_CANCEL = 2'd3;

  localparam logic [1:0] STAT_EXPIRED   = 2'd0;
  localparam logic [1:0] STAT_CANCELLED = 2'd1;
  localparam logic [1:0] STAT_REJECTED  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_time;
    logic [30:0] delay_ms;
    logic [15:0] alarm_tag;
  } in_t;

  typedef struct packed {
    logic [15:0] out_tag;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

/* sv/sdtq_cell.sv */
module sdtq_cell #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdtq_pkg::cell_ctl_t   ctl,
  input  logic [TIME_BITS-1:0]  new_dl,
  input  logic [15:0]           new_tag,
  input  logic [TIME_BITS-1:0]  left_dl,
  input  logic [15:0]           left_tag,
  input  logic                  left_valid,
  input  logic                  left_match,
  input  logic [TIME_BITS-1:0]  right_dl,
  input  logic [15:0]           right_tag,
  input  logic                  right_valid,
  input  logic                  any_match,
  output logic [TIME_BITS-1:0]  dl,
  output logic [15:0]           tag,
  output logic                  valid,
  output logic                  match
);
  import sdtq_pkg::*;

  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  logic [15:0]          tag_r, tag_nxt;
  logic                 valid_r, valid_nxt;
  logic                 match_r, match_nxt;
  logic [TIME_BITS-1:0] diff;

  assign diff = new_dl - dl_r;

  always_comb begin
    dl_nxt    = dl_r;
    tag_nxt   = tag_r;
    valid_nxt = valid_r;
    match_nxt = match_r;
    if (ctl.cmp) begin
      // new deadline not earlier than this entry
      match_nxt = valid_r & ~diff[TIME_BITS-1];
    end
    if (ctl.pop) begin
      dl_nxt    = right_dl;
      tag_nxt   = right_tag;
      valid_nxt = right_valid;
    end else if (ctl.ins && !any_match) begin
      if (left_match) begin
        dl_nxt    = new_dl;
        tag_nxt   = new_tag;
        valid_nxt = 1'b1;
      end else begin
        dl_nxt    = left_dl;
        tag_nxt   = left_tag;
        valid_nxt = left_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r  <= dl_nxt;
    tag_r <= tag_nxt;
  end

  assign dl    = dl_r;
  assign tag   = tag_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

/* sv/sorted_deadline_timer_queue_core.sv */
// Tick: busy in the tick state; an expired result, if due, is strobed in the following cycle.
// Add: busy for a parallel compare, then a shift-insert; when full, busy only for the compare
// and the reject result is strobed in the following cycle.
// Set/cancel: busy in the flush state until the queue is empty, one cancelled result per cycle,
// each strobed in the cycle after its pop; set then goes on to the compare and shift-insert.
// Synchronous active-low reset empties the queue; results strobe once, no stall.
module sorted_deadline_timer_queue_core #(
  parameter int QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = sdtq_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sdtq_pkg::in_t in_data,
  output logic          out_valid,
  output sdtq_pkg::out_t out_data
);
  import sdtq_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TICK  = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_INS   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           req_r;
  logic [15:0]          tag_r;
  logic [TIME_BITS-1:0] dl_r, now_r;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;
  cell_ctl_t            ctl;
  logic                 accept;

  logic [TIME_BITS+32:0] sum_w, now_w;
  logic [TIME_BITS-1:0]  head_diff;
  logic                  head_due;

  logic [TIME_BITS-1:0] cell_dl [QUEUE_DEPTH];
  logic [15:0]          cell_tag [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid, cell_match, any_match;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  assign now_w = {{(TIME_BITS+1){1'b0}}, in_data.now_time};
  assign sum_w = now_w + {{(TIME_BITS+2){1'b0}}, in_data.delay_ms};

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data.req_type;
      tag_r <= in_data.alarm_tag;
      dl_r  <= sum_w[TIME_BITS-1:0];
      now_r <= now_w[TIME_BITS-1:0];
    end
  end

  assign head_diff = now_r - cell_dl[0];
  assign head_due  = cell_valid[0] & ~head_diff[TIME_BITS-1];

  // match anywhere at or behind each cell
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      any_match[i] = |(cell_match >> i);
    end
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [TIME_BITS-1:0] l_dl, r_dl;
      logic [15:0]          l_tag, r_tag;
      logic                 l_valid, l_match, r_valid;
      if (g == 0) begin : g_head
        assign l_dl    = dl_r;
        assign l_tag   = tag_r;
        assign l_valid = 1'b1;
        assign l_match = 1'b1;
      end else begin : g_body
        assign l_dl    = cell_dl[g-1];
        assign l_tag   = cell_tag[g-1];
        assign l_valid = cell_valid[g-1];
        assign l_match = cell_match[g-1];
      end
      if (g == QUEUE_DEPTH-1) begin : g_tail
        assign r_dl    = cell_dl[g];
        assign r_tag   = cell_tag[g];
        assign r_valid = 1'b0;
      end else begin : g_mid
        assign r_dl    = cell_dl[g+1];
        assign r_tag   = cell_tag[g+1];
        assign r_valid = cell_valid[g+1];
      end
      sdtq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .new_dl      (dl_r),
        .new_tag     (tag_r),
        .left_dl     (l_dl),
        .left_tag    (l_tag),
        .left_valid  (l_valid),
        .left_match  (l_match),
        .right_dl    (r_dl),
        .right_tag   (r_tag),
        .right_valid (r_valid),
        .any_match   (any_match[g]),
        .dl          (cell_dl[g]),
        .tag         (cell_tag[g]),
        .valid       (cell_valid[g]),
        .match       (cell_match[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.req_type)
            REQ_TICK: state_nxt = ST_TICK;
            REQ_ADD:  state_nxt = ST_CMP;
            default:  state_nxt = ST_FLUSH;
          endcase
        end
      end
      ST_TICK: begin
        if (head_due) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.out_tag = cell_tag[0];
          out_data_nxt.status  = STAT_EXPIRED;
          out_data_nxt.last    = 1'b1;
          ctl.pop              = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_CMP: begin
        ctl.cmp = 1'b1;
        if (req_r == REQ_ADD && cell_valid[QUEUE_DEPTH-1]) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.out_tag = tag_r;
          out_data_nxt.status  = STAT_REJECTED;
          out_data_nxt.last    = 1'b1;
          state_nxt            = ST_IDLE;
        end else begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        ctl.ins   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FLUSH: begin
        if (cell_valid[0]) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.out_tag = cell_tag[0];
          out_data_nxt.status  = STAT_CANCELLED;
          out_data_nxt.last    = !cell_valid[1];
          ctl.pop              = 1'b1;
        end
        if (!cell_valid[1]) begin
          state_nxt = (req_r == REQ_SET) ? ST_CMP : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/sdtq_chk.sv */
module sdtq_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input sdtq_pkg::out_t out_data
);
  import sdtq_pkg::*;

  // an accepted transaction raises busy in the cycle after it is accepted
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a flush delivers its cancelled results on consecutive cycles
  a_flush_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("gap inside a cancel burst");

  // expired and rejected results are always single-result transactions
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STAT_EXPIRED || out_data.status == STAT_REJECTED))
      |-> out_data.last)
    else $error("single result without last");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("not idle after reset");

endmodule

bind sorted_deadline_timer_queue_core sdtq_chk u_sdtq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* test/testbench.sv */
module testbench;
  import sdtq_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  sorted_deadline_timer_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // alarm queue mirror
  logic [31:0] due_q [DEPTH];
  logic [15:0] tag_q [DEPTH];
  int unsigned pending = 0;
  out_t        alarm_results [$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned req_count [4];
  int unsigned fired = 0, cancelled = 0, rejected = 0;
  bit          no_idle = 1'b0;
  logic [31:0] clock_ms = 32'd0;
  out_t        want;

  function automatic bit not_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return ~diff[31];
  endfunction

  function automatic void push_result(input logic [15:0] tag, input logic [1:0] st,
                                      input logic last);
    out_t r;
    r.out_tag = tag;
    r.status  = st;
    r.last    = last;
    alarm_results.push_back(r);
  endfunction

  function automatic void cancel_pending();
    for (int i = 0; i < pending; i++) begin
      push_result(tag_q[i], STAT_CANCELLED, (i == pending - 1));
      cancelled++;
    end
    pending = 0;
  endfunction

  function automatic void insert_alarm(input logic [31:0] due, input logic [15:0] tag);
    int pos;
    pos = 0;
    for (int i = pending; i > 0; i--) begin
      if (not_before(due, due_q[i-1])) begin
        pos = i;
        break;
      end
    end
    for (int i = pending; i > pos; i--) begin
      due_q[i] = due_q[i-1];
      tag_q[i] = tag_q[i-1];
    end
    due_q[pos] = due;
    tag_q[pos] = tag;
    pending++;
  endfunction

  function automatic void apply_request(input in_t req);
    logic [31:0] due;
    due = req.now_time + {1'b0, req.delay_ms};
    req_count[req.req_type]++;
    case (req.req_type)
      REQ_TICK: begin
        if (pending != 0 && not_before(req.now_time, due_q[0])) begin
          push_result(tag_q[0], STAT_EXPIRED, 1'b1);
          fired++;
          for (int i = 1; i < pending; i++) begin
            due_q[i-1] = due_q[i];
            tag_q[i-1] = tag_q[i];
          end
          pending--;
        end
      end
      REQ_ADD: begin
        if (pending >= DEPTH) begin
          push_result(req.alarm_tag, STAT_REJECTED, 1'b1);
          rejected++;
        end else begin
          insert_alarm(due, req.alarm_tag);
        end
      end
      REQ_SET: begin
        cancel_pending();
        insert_alarm(due, req.alarm_tag);
      end
      default: cancel_pending();
    endcase
  endfunction

  // result check, then prediction of the transaction accepted at this edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (alarm_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual tag=%h status=%0d last=%b",
                 $time, out_data.out_tag, out_data.status, out_data.last);
      end else begin
        want = alarm_results.pop_front();
        if (out_data.out_tag !== want.out_tag) begin
          mismatches++;
          $display("%0t: out_tag mismatch: expected %h, actual %h",
                   $time, want.out_tag, out_data.out_tag);
        end
        if (out_data.status !== want.status) begin
          mismatches++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_data.status);
        end
        if (out_data.last !== want.last) begin
          mismatches++;
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, want.last, out_data.last);
        end
      end
    end
    if (rst_n && start && !busy) apply_request(in_data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, alarm_results.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic issue(input logic [1:0] kind, input logic [31:0] now,
                       input logic [30:0] delay, input logic [15:0] tag);
    in_t req;
    int  gap;
    req.req_type  = kind;
    req.now_time  = now;
    req.delay_ms  = delay;
    req.alarm_tag = tag;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
  endtask

  task automatic test_empty_queue();
    issue(REQ_TICK, 32'd0, 31'd0, 16'd0);
    issue(REQ_CANCEL, 32'd0, 31'd0, 16'd0);
    issue(REQ_SET, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF);
    issue(REQ_TICK, 32'h7FFF_FFFD, 31'd0, 16'd0);
    issue(REQ_TICK, 32'h7FFF_FFFE, 31'd0, 16'd0);
  endtask

  task automatic test_ordering_and_ties();
    issue(REQ_ADD, 32'd1000, 31'd50, 16'h0001);
    issue(REQ_ADD, 32'd1000, 31'd10, 16'h0002);
    issue(REQ_ADD, 32'd1000, 31'd50, 16'h0003);
    issue(REQ_ADD, 32'd1000, 31'd0, 16'h0000);
    issue(REQ_TICK, 32'd1000, 31'd0, 16'd0);
    issue(REQ_TICK, 32'd1010, 31'd0, 16'd0);
    issue(REQ_TICK, 32'd1049, 31'd0, 16'd0);
    issue(REQ_TICK, 32'd1060, 31'd0, 16'd0);
    issue(REQ_TICK, 32'd1060, 31'd0, 16'd0);
  endtask

  task automatic test_time_wrap();
    issue(REQ_ADD, 32'hFFFF_FFF0, 31'h20, 16'hA5A5);
    issue(REQ_ADD, 32'hFFFF_FFF0, 31'd0, 16'h5A5A);
    issue(REQ_TICK, 32'hFFFF_FFF8, 31'd0, 16'd0);
    issue(REQ_TICK, 32'h0000_0005, 31'd0, 16'd0);
    issue(REQ_TICK, 32'h0000_0010, 31'd0, 16'd0);
  endtask

  task automatic test_flush();
    issue(REQ_ADD, 32'd500, 31'd30, 16'h1111);
    issue(REQ_ADD, 32'd500, 31'd20, 16'h2222);
    issue(REQ_CANCEL, 32'd510, 31'd0, 16'd0);
    issue(REQ_ADD, 32'd520, 31'd5, 16'h3333);
    issue(REQ_SET, 32'd520, 31'd7, 16'h4444);
    issue(REQ_CANCEL, 32'd530, 31'd0, 16'd0);
  endtask

  task automatic fill_queue();
    for (int i = 0; i < DEPTH; i++)
      issue(REQ_ADD, clock_ms, 31'($urandom_range(0, 7) * 100), 16'($urandom));
  endtask

  task automatic test_queue_full();
    clock_ms = $urandom;
    issue(REQ_CANCEL, clock_ms, 31'd0, 16'd0);
    fill_queue();
    repeat (3) issue(REQ_ADD, clock_ms, 31'($urandom), 16'($urandom));
    issue(REQ_SET, clock_ms, 31'd3, 16'($urandom));
    issue(REQ_TICK, clock_ms + 32'd3, 31'd0, 16'd0);
    // back-to-back stretch: refill, then drain by ticks
    no_idle = 1'b1;
    fill_queue();
    issue(REQ_ADD, clock_ms, 31'd1, 16'($urandom));
    clock_ms = clock_ms + 32'd1000;
    repeat (DEPTH) issue(REQ_TICK, clock_ms, 31'd0, 16'd0);
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    int          pick;
    logic [30:0] delay;
    for (int n = 0; n < 60; n++) begin
      pick = $urandom_range(0, 99);
      clock_ms = clock_ms + 32'($urandom_range(0, 20));
      delay = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 60));
      if (n == 30) no_idle = 1'b1;
      if (n == 42) no_idle = 1'b0;
      if (pick < 45)
        issue(REQ_ADD, clock_ms, delay, 16'($urandom));
      else if (pick < 82)
        issue(REQ_TICK, clock_ms, 31'($urandom), 16'($urandom));
      else if (pick < 85)
        issue(REQ_TICK, $urandom, 31'd0, 16'd0);
      else if (pick < 94)
        issue(REQ_SET, clock_ms, delay, 16'($urandom));
      else
        issue(REQ_CANCEL, clock_ms, 31'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_ordering_and_ties();
    test_time_wrap();
    test_flush();
    test_queue_full();
    test_random_mix();
    start <= 1'b0;
    while (alarm_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("requests: %0d ticks, %0d adds, %0d sets, %0d cancels",
             req_count[REQ_TICK], req_count[REQ_ADD], req_count[REQ_SET],
             req_count[REQ_CANCEL]);
    $display("alarms: %0d expired, %0d cancelled, %0d rejected; %0d mismatches",
             fired, cancelled, rejected, mismatches);
    if (alarm_results.size() != 0) begin
      $display("%0t: %0d results expected, none seen", $time, alarm_results.size());
    end
    if (mismatches == 0 && alarm_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
